[hw/rtl/uwc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package uwc_pkg;

  // Stage count limits and default
  localparam int unsigned CordicStagesMin = 8;
  localparam int unsigned CordicStagesMax = 24;
  localparam int unsigned CordicStagesDef = 16;

  // Datapath widths
  localparam int unsigned DW  = 17;  // position error, Q8.8
  localparam int unsigned XW  = 27;  // rotator x/y with 8 guard bits and growth
  localparam int unsigned ZW  = 32;  // residual angle, 2^32 per turn
  localparam int unsigned SQW = 34;  // dx^2 + dy^2
  localparam int unsigned TSW = 30;  // threshold squared
  localparam int unsigned PW  = 58;  // x times scale factor
  localparam int unsigned VW  = 19;  // unsaturated cross component
  localparam int unsigned GPW = 36;  // cross component times gain
  localparam int unsigned SW  = 40;  // saturator input

  // Register indexes
  typedef enum logic {
    REG_REACH_THRESHOLD = 1'b0,
    REG_TURN_GAIN       = 1'b1
  } reg_idx_e;

  localparam logic [14:0] ReachThresholdRst = 15'd128;
  localparam logic [15:0] TurnGainRst       = 16'd21845;

  // atan(2^-i) in 2^32-per-turn units
  localparam logic [ZW-1:0] AtanTab [CordicStagesMax] = '{
    32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10680350, 32'd5340245, 32'd2670163, 32'd1335086,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41721, 32'd20860,
    32'd10430, 32'd5215, 32'd2607, 32'd1303, 32'd651, 32'd325, 32'd162, 32'd81
  };

  // Rotator scale factor, Q0.30, by stage count minus eight
  localparam logic [29:0] ScaleTab [17] = '{
    30'd652039508, 30'd652034533, 30'd652033289, 30'd652032979, 30'd652032901,
    30'd652032881, 30'd652032877, 30'd652032875, 30'd652032875, 30'd652032875,
    30'd652032875, 30'd652032875, 30'd652032875, 30'd652032875, 30'd652032875,
    30'd652032875, 30'd652032875
  };

  typedef struct packed {
    logic signed [15:0] pose_x;
    logic signed [15:0] pose_y;
    logic signed [15:0] pose_heading;
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
  } in_t;

  typedef struct packed {
    logic signed [15:0] forward_speed;
    logic signed [15:0] turn_rate;
    logic               reached;
  } out_t;

  // Rotator beat: vector, residual angle and reach flag
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 reached;
  } rot_t;

  function automatic logic signed [15:0] sat16(logic signed [SW-1:0] v);
    logic signed [15:0] r;
    if (v > SW'(32767)) begin
      r = 16'sh7fff;
    end else if (v < -SW'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/uwc_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module uwc_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic                        valid_i,
  input  wire uwc_pkg::in_t                data_i,
  input  wire logic [uwc_pkg::TSW-1:0]     thr_sq_i,
  output logic                             valid_o,
  output uwc_pkg::rot_t                    rot_o
);

  logic                              v1_q, v2_q;
  logic signed [uwc_pkg::DW-1:0]     dx_q, dy_q;
  logic signed [32:0]                z1_q;
  logic signed [16:0]                neg_hd;
  logic signed [2*uwc_pkg::DW-1:0]   sqx_d, sqy_d;
  logic [uwc_pkg::SQW-1:0]           sqx_q, sqy_q;
  logic signed [uwc_pkg::XW-1:0]     x_d, y_d, x_q, y_q;
  logic signed [32:0]                z_d;
  logic signed [uwc_pkg::ZW-1:0]     z_q;
  logic [uwc_pkg::SQW-1:0]           d2;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  // Stage one: position error and negated heading angle
  assign neg_hd = -{data_i.pose_heading[15], data_i.pose_heading};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q <= {data_i.target_x[15], data_i.target_x} - {data_i.pose_x[15], data_i.pose_x};
      dy_q <= {data_i.target_y[15], data_i.target_y} - {data_i.pose_y[15], data_i.pose_y};
      z1_q <= {neg_hd, 16'd0};
    end
  end

  // Stage two: squares and pre-rotation by pi beyond a quarter turn
  assign sqx_d = dx_q * dx_q;
  assign sqy_d = dy_q * dy_q;

  always_comb begin
    x_d = {{(uwc_pkg::XW-uwc_pkg::DW-8){dx_q[uwc_pkg::DW-1]}}, dx_q, 8'd0};
    y_d = {{(uwc_pkg::XW-uwc_pkg::DW-8){dy_q[uwc_pkg::DW-1]}}, dy_q, 8'd0};
    z_d = z1_q;
    if (z1_q > 33'sd1073741824) begin
      x_d = -x_d;
      y_d = -y_d;
      z_d = z1_q - 33'sd2147483648;
    end else if (z1_q < -33'sd1073741824) begin
      x_d = -x_d;
      y_d = -y_d;
      z_d = z1_q + 33'sd2147483648;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqx_q <= uwc_pkg::SQW'(unsigned'(sqx_d[2*uwc_pkg::DW-2:0]));
      sqy_q <= uwc_pkg::SQW'(unsigned'(sqy_d[2*uwc_pkg::DW-2:0]));
      x_q   <= x_d;
      y_q   <= y_d;
      z_q   <= z_d[uwc_pkg::ZW-1:0];
    end
  end

  // Reach test on squared distances
  assign d2              = sqx_q + sqy_q;
  assign valid_o         = v2_q;
  assign rot_o.x         = x_q;
  assign rot_o.y         = y_q;
  assign rot_o.z         = z_q;
  assign rot_o.reached   = d2 < uwc_pkg::SQW'(thr_sq_i);

endmodule
`default_nettype wire

[hw/rtl/uwc_cordic.sv]
`timescale 1ns / 1ps
`default_nettype none
module uwc_cordic #(
  parameter int unsigned STAGES = uwc_pkg::CordicStagesDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire uwc_pkg::rot_t rot_i,
  output logic               valid_o,
  output uwc_pkg::rot_t      rot_o
);

  uwc_pkg::rot_t st_in [STAGES];
  uwc_pkg::rot_t st_d  [STAGES];
  uwc_pkg::rot_t st_q  [STAGES];
  logic          vl_q  [STAGES];

  assign st_in[0] = rot_i;

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    if (i > 0) begin : g_link
      assign st_in[i] = st_q[i-1];
    end

    // Rotate towards zero residual angle
    always_comb begin
      st_d[i] = st_in[i];
      if (!st_in[i].z[uwc_pkg::ZW-1]) begin
        st_d[i].x = st_in[i].x - (st_in[i].y >>> i);
        st_d[i].y = st_in[i].y + (st_in[i].x >>> i);
        st_d[i].z = st_in[i].z - signed'(uwc_pkg::AtanTab[i]);
      end else begin
        st_d[i].x = st_in[i].x + (st_in[i].y >>> i);
        st_d[i].y = st_in[i].y - (st_in[i].x >>> i);
        st_d[i].z = st_in[i].z + signed'(uwc_pkg::AtanTab[i]);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vl_q[i] <= 1'b0;
      end else if (en_i) begin
        vl_q[i] <= (i == 0) ? valid_i : vl_q[(i == 0) ? 0 : i-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[i] <= st_d[i];
      end
    end
  end

  assign valid_o = vl_q[STAGES-1];
  assign rot_o   = st_q[STAGES-1];

endmodule
`default_nettype wire

[hw/rtl/uwc_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module uwc_back #(
  parameter int unsigned STAGES = uwc_pkg::CordicStagesDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire uwc_pkg::rot_t rot_i,
  input  wire logic [15:0]   turn_gain_i,
  output logic               valid_o,
  output uwc_pkg::out_t      data_o
);

  localparam logic [29:0] Scale = uwc_pkg::ScaleTab[STAGES - uwc_pkg::CordicStagesMin];
  localparam logic signed [uwc_pkg::PW-1:0] RoundP = uwc_pkg::PW'(64'sd1 <<< 37);

  logic                               v1_q, v2_q, v3_q;
  logic                               r1_q, r2_q;
  logic signed [uwc_pkg::PW-1:0]      px_q, py_q, pxr, pyr;
  logic signed [uwc_pkg::VW-1:0]      v_val;
  logic signed [19:0]                 u_val, w_val;
  logic signed [15:0]                 u_q;
  logic signed [uwc_pkg::GPW-1:0]     gp_q, gpr;
  uwc_pkg::out_t                      out_q;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Gain correction products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q <= uwc_pkg::PW'(rot_i.x * signed'({1'b0, Scale}));
      py_q <= uwc_pkg::PW'(rot_i.y * signed'({1'b0, Scale}));
      r1_q <= rot_i.reached;
    end
  end

  // Round to Q.8, saturate forward speed, scale cross component by gain
  assign pxr   = px_q + RoundP;
  assign pyr   = py_q + RoundP;
  assign u_val = pxr[uwc_pkg::PW-1:38];
  assign v_val = pyr[38+uwc_pkg::VW-1:38];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u_q  <= uwc_pkg::sat16(uwc_pkg::SW'(u_val));
      gp_q <= uwc_pkg::GPW'(v_val * signed'({1'b0, turn_gain_i}));
      r2_q <= r1_q;
    end
  end

  // Round turn rate, saturate, zero both when reached
  assign gpr   = gp_q + uwc_pkg::GPW'(32768);
  assign w_val = gpr[uwc_pkg::GPW-1:16];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q.reached       <= r2_q;
      out_q.forward_speed <= r2_q ? 16'sd0 : u_q;
      out_q.turn_rate     <= r2_q ? 16'sd0 : uwc_pkg::sat16(uwc_pkg::SW'(w_val));
    end
  end

  assign valid_o = v3_q;
  assign data_o  = out_q;

endmodule
`default_nettype wire

[hw/rtl/unicycle_waypoint_controller_unit.sv]
// Point-tracking controller for a unicycle robot. Each input beat carries a pose
// (Q7.8 position, binary-angle heading) and a target; the result beat carries the
// forward speed and turn rate in Q7.8 and a reached flag (speeds zero when set).
// One beat is taken every cycle while the output is not stalled; the pipeline is
// the rotator stages plus two front and three back stages. A stall on the output
// holds the whole pipeline. Threshold and gain may be written only while idle;
// a new threshold takes effect after the threshold and square registers.
`timescale 1ns / 1ps
`default_nettype none
module unicycle_waypoint_controller_unit #(
  parameter int unsigned CORDIC_STAGES = uwc_pkg::CordicStagesDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire uwc_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output uwc_pkg::out_t      out_data_o,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_idx_i,
  input  wire logic [15:0]   cfg_data_i
);

  localparam int unsigned Stages =
    (CORDIC_STAGES < uwc_pkg::CordicStagesMin) ? uwc_pkg::CordicStagesMin :
    (CORDIC_STAGES > uwc_pkg::CordicStagesMax) ? uwc_pkg::CordicStagesMax : CORDIC_STAGES;

  logic                         en;
  logic [14:0]                  thr_q;
  logic [15:0]                  gain_q;
  logic [uwc_pkg::TSW-1:0]      thr_sq_q;
  logic                         fv, cv;
  uwc_pkg::rot_t                frot, crot;

  // Advance whenever the output register is free or being taken
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= uwc_pkg::ReachThresholdRst;
      gain_q <= uwc_pkg::TurnGainRst;
    end else if (cfg_we_i) begin
      unique case (uwc_pkg::reg_idx_e'(cfg_idx_i))
        uwc_pkg::REG_REACH_THRESHOLD: thr_q  <= cfg_data_i[14:0];
        uwc_pkg::REG_TURN_GAIN:       gain_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Square the threshold in its own register, off the item path
  always_ff @(posedge clk_i) begin
    thr_sq_q <= thr_q * thr_q;
  end

  uwc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_valid_i),
    .data_i   (in_data_i),
    .thr_sq_i (thr_sq_q),
    .valid_o  (fv),
    .rot_o    (frot)
  );

  uwc_cordic #(.STAGES(Stages)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fv),
    .rot_i   (frot),
    .valid_o (cv),
    .rot_o   (crot)
  );

  uwc_back #(.STAGES(Stages)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (cv),
    .rot_i       (crot),
    .turn_gain_i (gain_q),
    .valid_o     (out_valid_o),
    .data_o      (out_data_o)
  );

`ifndef NO_ASSERTIONS
  a_reached_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.reached |->
      out_data_o.forward_speed == 16'sd0 && out_data_o.turn_rate == 16'sd0)
    else $error("reached beat with nonzero speed");

  a_stall_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input blocked without output stall");

  a_thr_sq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $stable(thr_q) |=> thr_sq_q == uwc_pkg::TSW'($past(thr_q) * $past(thr_q)))
    else $error("threshold square out of step");
`endif

endmodule
`default_nettype wire
